// ===== rtl/core/wid_pkg.sv =====
// ----------------------------------------------------------------------------
// wid_pkg: shared types and constants for the wheel/IMU dead-reckoning block
// Command format between front and back, CORDIC constants, multiply codes.
// ----------------------------------------------------------------------------
package wid_pkg;

  // Item kinds (tuser)
  localparam logic FUNC_ORIENT = 1'b0;
  localparam logic FUNC_ENCODER = 1'b1;

  // Command queue geometry
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // CORDIC constants, Q2.30 radians
  localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [36:0] GAIN_INV_Q30 = 37'sd652032874;

  // Multiply sequence codes
  localparam logic [2:0] OP_INC_L = 3'd0;
  localparam logic [2:0] OP_INC_R = 3'd1;
  localparam logic [2:0] OP_DIST = 3'd2;
  localparam logic [2:0] OP_DX = 3'd3;
  localparam logic [2:0] OP_DY = 3'd4;

  // Rounding shifts
  localparam int unsigned SH_INC = 16;
  localparam int unsigned SH_DIST = 17;
  localparam int unsigned SH_POSE = 30;

  // Classified command as queued between front and back
  typedef struct packed {
    logic               kind;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [32:0] dl;
    logic signed [32:0] dr;
  } cmd_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Elementary rotation angle for CORDIC iteration i, Q2.30
  function automatic logic signed [34:0] atan_step(input logic [4:0] i);
    logic signed [34:0] r;
    unique case (i)
      5'd0: r = 35'sd843314857;
      5'd1: r = 35'sd497837829;
      5'd2: r = 35'sd263043837;
      5'd3: r = 35'sd133525159;
      5'd4: r = 35'sd67021687;
      5'd5: r = 35'sd33543516;
      5'd6: r = 35'sd16775851;
      5'd7: r = 35'sd8388437;
      5'd8: r = 35'sd4194283;
      5'd9: r = 35'sd2097149;
      default: r = (i <= 5'd30) ? (35'sd1 <<< (5'd30 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/wid_queue.sv =====
// ----------------------------------------------------------------------------
// wid_queue: short command queue between front and back
// Two-entry FIFO so the front keeps taking items while the back is busy.
// ----------------------------------------------------------------------------
module wid_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wid_pkg::cmd_t     cmd_i,
  input  logic              pop_i,
  output wid_pkg::cmd_t     cmd_o,
  output wid_pkg::q_stat_t  stat_o
);

  wid_pkg::cmd_t                    mem_q [wid_pkg::QUEUE_DEPTH];
  logic [wid_pkg::QPTR_W-1:0]       wp_q, wp_d, rp_q, rp_d;
  logic [wid_pkg::QCNT_W-1:0]       cnt_q, cnt_d;

  // Advance pointers and fill count
  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = pop_i ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  assign cmd_o        = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == wid_pkg::QCNT_W'(wid_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== rtl/core/wid_front.sv =====
// ----------------------------------------------------------------------------
// wid_front: input side of the dead-reckoning block
// Takes stream transfers, classifies them and forms the count deltas.
// ----------------------------------------------------------------------------
module wid_front (
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [191:0]          s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  wid_pkg::q_stat_t      stat_i,
  output logic                  push_o,
  output wid_pkg::cmd_t         cmd_o
);

  logic signed [31:0] ls, le, rs, re;

  assign ls = s_axis_tdata[95:64];
  assign le = s_axis_tdata[127:96];
  assign rs = s_axis_tdata[159:128];
  assign re = s_axis_tdata[191:160];

  // Accept whenever the queue has room
  assign s_axis_tready = !stat_i.full;
  assign push_o        = s_axis_tvalid && !stat_i.full;

  // Classify and form exact 33-bit deltas
  always_comb begin
    cmd_o.kind = (s_axis_tuser == wid_pkg::FUNC_ENCODER) ? wid_pkg::FUNC_ENCODER
                                                         : wid_pkg::FUNC_ORIENT;
    cmd_o.qx   = s_axis_tdata[15:0];
    cmd_o.qy   = s_axis_tdata[31:16];
    cmd_o.qz   = s_axis_tdata[47:32];
    cmd_o.qw   = s_axis_tdata[63:48];
    cmd_o.dl   = 33'(le) - 33'(ls);
    cmd_o.dr   = 33'(re) - 33'(rs);
  end

endmodule

// ===== rtl/core/wid_back.sv =====
// ----------------------------------------------------------------------------
// wid_back: sequencer for yaw extraction and pose update
// Shared CORDIC (vectoring for yaw, rotation for cos/sin) and a 17-bit digit
// multiplier that builds the exact wide products one partial product a cycle.
// ----------------------------------------------------------------------------
module wid_back #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned ACC_WIDTH    = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wid_pkg::cmd_t        cmd_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  input  logic [31:0]          rpt_i,
  input  logic [15:0]          wr_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          pos_x_o,
  output logic [31:0]          pos_y_o,
  output logic [14:0]          heading_o,
  output logic [31:0]          right_angle_o,
  output logic [31:0]          left_angle_o
);

  localparam int unsigned CW = $clog2(CORDIC_STEPS);
  localparam logic [CW-1:0] IT_LAST = CW'(CORDIC_STEPS - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_QPROD = 8'b0000_0010,
    S_LOCK  = 8'b0000_0100,
    S_VEC   = 8'b0000_1000,
    S_ROT   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_RND   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e                   state_q, state_d;
  wid_pkg::cmd_t            cmd_q, cmd_d;
  logic [2:0]               qk_q, qk_d;
  logic signed [33:0]       norm_q, norm_d;
  logic signed [32:0]       lock_q, lock_d, den_q, den_d, num_q, num_d;
  logic signed [36:0]       cx_q, cx_d, cy_q, cy_d;
  logic signed [34:0]       cz_q, cz_d;
  logic [CW-1:0]            it_q, it_d;
  logic                     neg_q, neg_d;
  logic signed [32:0]       cos_q, cos_d, sin_q, sin_d;
  logic [2:0]               op_q, op_d;
  logic [1:0]               dig_q, dig_d;
  logic signed [83:0]       prod_q, prod_d;
  logic signed [50:0]       inc_l_q, inc_l_d, inc_r_q, inc_r_d, dist_q, dist_d;
  logic signed [14:0]       yaw_q, yaw_d;
  logic [ACC_WIDTH-1:0]     xacc_q, xacc_d, yacc_q, yacc_d;
  logic [ACC_WIDTH-1:0]     racc_q, racc_d, lacc_q, lacc_d;

  // Quaternion product terms
  logic signed [15:0]       ma, mb;
  logic signed [31:0]       qp;
  // Lock test and vectoring start
  logic signed [33:0]       lock2, lock_abs, num2;
  logic signed [36:0]       vx, vy;
  logic signed [34:0]       vz, rz;
  // CORDIC step
  logic signed [36:0]       xs, ys, xn, yn;
  logic signed [34:0]       at, zn, ysum;
  logic                     sig_pos;
  // Digit multiplier
  logic signed [50:0]       opa, pp;
  logic signed [32:0]       opb;
  logic signed [17:0]       dig;
  logic signed [83:0]       ppw, rnd, rsh;
  logic signed [50:0]       res;

  // Select quaternion product for this step
  always_comb begin
    unique case (qk_q)
      3'd0:    begin ma = cmd_q.qw; mb = cmd_q.qw; end
      3'd1:    begin ma = cmd_q.qx; mb = cmd_q.qx; end
      3'd2:    begin ma = cmd_q.qy; mb = cmd_q.qy; end
      3'd3:    begin ma = cmd_q.qz; mb = cmd_q.qz; end
      3'd4:    begin ma = cmd_q.qx; mb = cmd_q.qz; end
      3'd5:    begin ma = cmd_q.qw; mb = cmd_q.qy; end
      3'd6:    begin ma = cmd_q.qw; mb = cmd_q.qz; end
      default: begin ma = cmd_q.qx; mb = cmd_q.qy; end
    endcase
    qp = ma * mb;
  end

  // Gimbal-lock test and vectoring start values
  always_comb begin
    lock2    = {lock_q, 1'b0};
    lock_abs = (lock2 < 0) ? -lock2 : lock2;
    num2     = {num_q, 1'b0};
    vx       = 37'(den_q);
    vy       = 37'(num2);
    vz       = '0;
    if (den_q < 0) begin
      vz = (vy >= 0) ? wid_pkg::PI_Q30 : -wid_pkg::PI_Q30;
      vx = -vx;
      vy = -vy;
    end
  end

  // Scale the stored yaw to Q2.30 radians; the fold into the right half-plane is done at rotation start
  assign rz = 35'(yaw_q) <<< 18;

  // One CORDIC micro-rotation; sig_pos selects x -= ys, y += xs, z -= at
  always_comb begin
    xs      = cx_q >>> it_q;
    ys      = cy_q >>> it_q;
    at      = wid_pkg::atan_step(5'(it_q));
    sig_pos = (state_q == S_VEC) ? !(cy_q > 0) : (cz_q >= 0);
    if (sig_pos) begin
      xn = cx_q - ys;
      yn = cy_q + xs;
      zn = cz_q - at;
    end else begin
      xn = cx_q + ys;
      yn = cy_q - xs;
      zn = cz_q + at;
    end
    ysum = zn + 35'sd131072;
  end

  // Operands and one signed 18 x 33 partial product
  always_comb begin
    unique case (op_q)
      wid_pkg::OP_INC_L: begin opa = 51'(cmd_q.dl); opb = $signed({1'b0, rpt_i}); end
      wid_pkg::OP_INC_R: begin opa = 51'(cmd_q.dr); opb = $signed({1'b0, rpt_i}); end
      wid_pkg::OP_DIST:  begin opa = inc_l_q + inc_r_q; opb = $signed({17'b0, wr_i}); end
      wid_pkg::OP_DX:    begin opa = dist_q; opb = cos_q; end
      default:           begin opa = dist_q; opb = sin_q; end
    endcase
    unique case (dig_q)
      2'd0:    dig = $signed({1'b0, opa[16:0]});
      2'd1:    dig = $signed({1'b0, opa[33:17]});
      default: dig = $signed({opa[50], opa[50:34]});
    endcase
    pp = dig * opb;
    unique case (dig_q)
      2'd0:    ppw = 84'(pp);
      2'd1:    ppw = 84'(pp) <<< 17;
      default: ppw = 84'(pp) <<< 34;
    endcase
    unique case (op_q)
      wid_pkg::OP_INC_L, wid_pkg::OP_INC_R: begin
        rnd = prod_q + (84'sd1 <<< (wid_pkg::SH_INC - 1));
        rsh = rnd >>> wid_pkg::SH_INC;
      end
      wid_pkg::OP_DIST: begin
        rnd = prod_q + (84'sd1 <<< (wid_pkg::SH_DIST - 1));
        rsh = rnd >>> wid_pkg::SH_DIST;
      end
      default: begin
        rnd = prod_q + (84'sd1 <<< (wid_pkg::SH_POSE - 1));
        rsh = rnd >>> wid_pkg::SH_POSE;
      end
    endcase
    res = rsh[50:0];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    qk_d    = qk_q;
    norm_d  = norm_q;
    lock_d  = lock_q;
    den_d   = den_q;
    num_d   = num_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    it_d    = it_q;
    neg_d   = neg_q;
    cos_d   = cos_q;
    sin_d   = sin_q;
    op_d    = op_q;
    dig_d   = dig_q;
    prod_d  = prod_q;
    inc_l_d = inc_l_q;
    inc_r_d = inc_r_q;
    dist_d  = dist_q;
    yaw_d   = yaw_q;
    xacc_d  = xacc_q;
    yacc_d  = yacc_q;
    racc_d  = racc_q;
    lacc_d  = lacc_q;
    cmd_pop_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          it_d      = '0;
          if (cmd_i.kind == wid_pkg::FUNC_ENCODER) begin
            // Start rotation of the stored yaw
            cx_d  = wid_pkg::GAIN_INV_Q30;
            cy_d  = '0;
            cz_d  = rz;
            neg_d = 1'b0;
            if (rz > wid_pkg::HALF_PI_Q30) begin
              cz_d  = rz - wid_pkg::PI_Q30;
              neg_d = 1'b1;
            end else if (rz < -wid_pkg::HALF_PI_Q30) begin
              cz_d  = rz + wid_pkg::PI_Q30;
              neg_d = 1'b1;
            end
            state_d = S_ROT;
          end else begin
            qk_d    = '0;
            norm_d  = '0;
            lock_d  = '0;
            den_d   = '0;
            num_d   = '0;
            state_d = S_QPROD;
          end
        end
      end
      S_QPROD: begin
        // Accumulate one quaternion product a cycle
        unique case (qk_q)
          3'd0, 3'd1: begin
            norm_d = norm_q + 34'(qp);
            den_d  = den_q + 33'(qp);
          end
          3'd2, 3'd3: begin
            norm_d = norm_q + 34'(qp);
            den_d  = den_q - 33'(qp);
          end
          3'd4:    lock_d = lock_q + 33'(qp);
          3'd5:    lock_d = lock_q - 33'(qp);
          default: num_d = num_q + 33'(qp);
        endcase
        qk_d = qk_q + 1'b1;
        if (qk_q == 3'd7) begin
          state_d = S_LOCK;
        end
      end
      S_LOCK: begin
        if (lock_abs >= norm_q) begin
          yaw_d   = '0;
          state_d = S_IDLE;
        end else begin
          cx_d    = vx;
          cy_d    = vy;
          cz_d    = vz;
          it_d    = '0;
          state_d = S_VEC;
        end
      end
      S_VEC: begin
        cx_d = xn;
        cy_d = yn;
        cz_d = zn;
        it_d = it_q + 1'b1;
        if (it_q == IT_LAST) begin
          yaw_d   = ysum[32:18];
          state_d = S_IDLE;
        end
      end
      S_ROT: begin
        cx_d = xn;
        cy_d = yn;
        cz_d = zn;
        it_d = it_q + 1'b1;
        if (it_q == IT_LAST) begin
          cos_d   = neg_q ? 33'(-xn) : 33'(xn);
          sin_d   = neg_q ? 33'(-yn) : 33'(yn);
          op_d    = wid_pkg::OP_INC_L;
          dig_d   = '0;
          prod_d  = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = prod_q + ppw;
        dig_d  = dig_q + 1'b1;
        if (dig_q == 2'd2) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        // Store rounded product, fold into accumulators
        op_d    = op_q + 1'b1;
        dig_d   = '0;
        prod_d  = '0;
        state_d = S_MUL;
        unique case (op_q)
          wid_pkg::OP_INC_L: begin
            inc_l_d = res;
            lacc_d  = lacc_q + ACC_WIDTH'(res);
          end
          wid_pkg::OP_INC_R: begin
            inc_r_d = res;
            racc_d  = racc_q + ACC_WIDTH'(res);
          end
          wid_pkg::OP_DIST: dist_d = res;
          wid_pkg::OP_DX:   xacc_d = xacc_q + ACC_WIDTH'(res);
          default: begin
            yacc_d  = yacc_q + ACC_WIDTH'(res);
            state_d = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      yaw_q   <= '0;
      xacc_q  <= '0;
      yacc_q  <= '0;
      racc_q  <= '0;
      lacc_q  <= '0;
    end else begin
      state_q <= state_d;
      yaw_q   <= yaw_d;
      xacc_q  <= xacc_d;
      yacc_q  <= yacc_d;
      racc_q  <= racc_d;
      lacc_q  <= lacc_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    qk_q    <= qk_d;
    norm_q  <= norm_d;
    lock_q  <= lock_d;
    den_q   <= den_d;
    num_q   <= num_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    it_q    <= it_d;
    neg_q   <= neg_d;
    cos_q   <= cos_d;
    sin_q   <= sin_d;
    op_q    <= op_d;
    dig_q   <= dig_d;
    prod_q  <= prod_d;
    inc_l_q <= inc_l_d;
    inc_r_q <= inc_r_d;
    dist_q  <= dist_d;
  end

  assign out_valid_o   = (state_q == S_OUT);
  assign pos_x_o       = 32'($signed(xacc_q));
  assign pos_y_o       = 32'($signed(yacc_q));
  assign right_angle_o = 32'($signed(racc_q));
  assign left_angle_o  = 32'($signed(lacc_q));
  assign heading_o     = yaw_q;

endmodule

// ===== rtl/core/wheel_imu_dead_reckoning.sv =====
// ----------------------------------------------------------------------------
// wheel_imu_dead_reckoning: wheel odometry with IMU yaw
// Stream in orientation and encoder samples, stream out pose and wheel angles.
// ----------------------------------------------------------------------------
// An orientation sample (tuser 0) updates the stored yaw and gives no output;
// an encoder sample (tuser 1) advances x/y along the stored yaw, accumulates
// both wheel angles and gives one output transfer. A two-entry queue sits
// behind the input, so items are taken while the back end works. The back end
// handles one item at a time: an orientation sample runs eight quaternion
// products on one 16x16 multiplier, then the shared CORDIC in vectoring mode
// (skipped when the gimbal-lock test forces the yaw to zero); an encoder
// sample runs CORDIC rotation, then five exact wide products built from three
// 18x33 partial products each, then presents the output, held for as long as
// the output is stalled.
// ----------------------------------------------------------------------------
module wheel_imu_dead_reckoning #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned ACC_WIDTH    = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w, left_start, left_end, right_start,
  // right_end
  input  logic [191:0]  s_axis_tdata,
  // func
  input  logic          s_axis_tuser,
  // Output stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // pos_x, pos_y, heading, right_angle, left_angle, zero pad bit
  output logic [143:0]  m_axis_tdata,
  // Configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam logic IDX_RPT = 1'b0;
  localparam logic IDX_WR  = 1'b1;

  logic [31:0]       rpt_q, rpt_d;
  logic [15:0]       wr_q, wr_d;
  logic              cfg_wr;

  wid_pkg::cmd_t     f_cmd, q_cmd;
  wid_pkg::q_stat_t  q_stat;
  logic              push, pop;
  logic [31:0]       pos_x, pos_y, r_ang, l_ang;
  logic [14:0]       heading;

  // Register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    rpt_d = rpt_q;
    wr_d  = wr_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        IDX_RPT: rpt_d = pwdata;
        default: wr_d  = pwdata[15:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpt_q <= 32'd294930;
      wr_q  <= 16'd6658;
    end else begin
      rpt_q <= rpt_d;
      wr_q  <= wr_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      IDX_WR:  prdata = {16'b0, wr_q};
      default: prdata = rpt_q;
    endcase
  end

  // Front, queue, back
  wid_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .stat_i        (q_stat),
    .push_o        (push),
    .cmd_o         (f_cmd)
  );

  wid_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (f_cmd),
    .pop_i  (pop),
    .cmd_o  (q_cmd),
    .stat_o (q_stat)
  );

  wid_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (q_cmd),
    .cmd_valid_i   (!q_stat.empty),
    .cmd_pop_o     (pop),
    .rpt_i         (rpt_q),
    .wr_i          (wr_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pos_x_o       (pos_x),
    .pos_y_o       (pos_y),
    .heading_o     (heading),
    .right_angle_o (r_ang),
    .left_angle_o  (l_ang)
  );

  assign m_axis_tdata = {1'b0, l_ang, r_ang, heading, pos_y, pos_x};

  // Queue and sequencer consistency
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty) else $error("pop from empty command queue");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full) else $error("push into full command queue");

  a_no_pop_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !pop) else $error("command taken while result pending");

  a_pop_then_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop && !m_axis_tvalid) else $error("back end did not start work");

endmodule
